FILE: rtl/tgc_pkg.sv
package tgc_pkg;

    // Coordinate width of the touch samples
    localparam int COORD_BITS = 12;

    // Fixed register widths
    localparam int RADIUS_BITS = 25;
    localparam int TRAVEL_BITS = 12;
    localparam int CFG_DATA_BITS = 25;
    localparam int CFG_INDEX_BITS = 2;

    // Squared distance and compare widths
    localparam int DIST_BITS = 2 * COORD_BITS + 1;
    localparam int DIST_CMP_BITS = (DIST_BITS > RADIUS_BITS) ? DIST_BITS : RADIUS_BITS;
    localparam int TRAV_CMP_BITS = (COORD_BITS > TRAVEL_BITS) ? COORD_BITS : TRAVEL_BITS;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_RADIUS_SQ = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SWIPE_MIN_TRAVEL = 2'd2;

    // Configuration reset values
    localparam logic [RADIUS_BITS-1:0] TAP_RADIUS_SQ_RST = RADIUS_BITS'(30 * 30);
    localparam logic [TRAVEL_BITS-1:0] SWIPE_MIN_TRAVEL_RST = TRAVEL_BITS'(40);

    // Controller gesture codes
    localparam logic [7:0] CTL_UP = 8'h01;
    localparam logic [7:0] CTL_DOWN = 8'h02;
    localparam logic [7:0] CTL_LEFT = 8'h03;
    localparam logic [7:0] CTL_RIGHT = 8'h04;
    localparam logic [7:0] CTL_TAP = 8'h05;

    // Captured code values (low bits of the controller code)
    localparam logic [2:0] CAP_NONE = 3'd0;
    localparam logic [2:0] CAP_UP = 3'd1;
    localparam logic [2:0] CAP_DOWN = 3'd2;
    localparam logic [2:0] CAP_LEFT = 3'd3;
    localparam logic [2:0] CAP_RIGHT = 3'd4;
    localparam logic [2:0] CAP_TAP = 3'd5;

    // Published gesture codes
    localparam logic [2:0] G_NONE = 3'd0;
    localparam logic [2:0] G_TAP = 3'd1;
    localparam logic [2:0] G_LEFT = 3'd2;
    localparam logic [2:0] G_RIGHT = 3'd3;
    localparam logic [2:0] G_UP = 3'd4;
    localparam logic [2:0] G_DOWN = 3'd5;

    typedef struct packed {
        logic                  read_error;
        logic [3:0]            finger_count;
        logic                  sample_valid;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [7:0]            gesture_code;
    } in_item_t;

    typedef struct packed {
        logic [2:0]            gesture;
        logic                  pressed;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
    } out_item_t;

    typedef struct packed {
        logic                   enable;
        logic [RADIUS_BITS-1:0] tap_radius_sq;
        logic [TRAVEL_BITS-1:0] swipe_min_travel;
    } cfg_t;

    // Touch state seen by the release classifier
    typedef struct packed {
        logic [2:0]            captured_code;
        logic [COORD_BITS-1:0] origin_x;
        logic [COORD_BITS-1:0] origin_y;
        logic [COORD_BITS-1:0] last_x;
        logic [COORD_BITS-1:0] last_y;
    } touch_state_t;

endpackage

FILE: rtl/tgc_release_classify.sv
module tgc_release_classify
    import tgc_pkg::*;
(
    input  touch_state_t st,
    input  cfg_t         cfg,
    output logic [2:0]   gesture
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]        neg_dx;
    logic [COORD_BITS:0]        neg_dy;
    logic [COORD_BITS-1:0]      adx;
    logic [COORD_BITS-1:0]      ady;
    logic [2*COORD_BITS-1:0]    sq_x;
    logic [2*COORD_BITS-1:0]    sq_y;
    logic [DIST_BITS-1:0]       dist_sq;
    logic                       in_radius;
    logic                       vertical;

    assign dx = $signed({1'b0, st.last_x}) - $signed({1'b0, st.origin_x});
    assign dy = $signed({1'b0, st.last_y}) - $signed({1'b0, st.origin_y});
    assign neg_dx = -dx;
    assign neg_dy = -dy;
    assign adx = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    assign sq_x = adx * adx;
    assign sq_y = ady * ady;
    assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};

    assign in_radius = DIST_CMP_BITS'(dist_sq) <= DIST_CMP_BITS'(cfg.tap_radius_sq);
    assign vertical  = (ady > adx)
                    && (TRAV_CMP_BITS'(ady) >= TRAV_CMP_BITS'(cfg.swipe_min_travel));

    // Captured swipe wins, then tap, then a synthesized vertical swipe
    always_comb begin
        case (st.captured_code)
            CAP_LEFT:  gesture = G_LEFT;
            CAP_RIGHT: gesture = G_RIGHT;
            CAP_UP:    gesture = G_UP;
            CAP_DOWN:  gesture = G_DOWN;
            CAP_TAP:   gesture = G_TAP;
            default: begin
                if (in_radius) begin
                    gesture = G_TAP;
                end else if (vertical) begin
                    gesture = dy[COORD_BITS] ? G_UP : G_DOWN;
                end else begin
                    gesture = G_NONE;
                end
            end
        endcase
    end

endmodule

FILE: rtl/tgc_track.sv
module tgc_track
    import tgc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic         finger_down_reg;
    logic         finger_down_next;
    logic         origin_seeded_reg;
    logic         origin_seeded_next;
    touch_state_t st_reg;
    touch_state_t st_next;
    logic [2:0]   release_gesture;
    logic         live;

    tgc_release_classify u_classify (
        .st      (st_reg),
        .cfg     (cfg),
        .gesture (release_gesture)
    );

    assign live = cfg.enable && !item.read_error;

    always_comb begin
        finger_down_next   = finger_down_reg;
        origin_seeded_next = origin_seeded_reg;
        st_next            = st_reg;
        result.gesture     = G_NONE;

        if (live && item.finger_count != 4'd0) begin
            finger_down_next = 1'b1;
            if (item.sample_valid) begin
                st_next.last_x = item.pos_x;
                st_next.last_y = item.pos_y;
                if (!origin_seeded_reg) begin
                    st_next.origin_x   = item.pos_x;
                    st_next.origin_y   = item.pos_y;
                    origin_seeded_next = 1'b1;
                end
            end
            // Swipe codes override; tap only when nothing captured yet
            if (item.gesture_code == CTL_UP || item.gesture_code == CTL_DOWN
                || item.gesture_code == CTL_LEFT || item.gesture_code == CTL_RIGHT) begin
                st_next.captured_code = item.gesture_code[2:0];
            end else if (item.gesture_code == CTL_TAP && st_reg.captured_code == CAP_NONE) begin
                st_next.captured_code = CAP_TAP;
            end
        end else if (live && finger_down_reg) begin
            result.gesture        = release_gesture;
            finger_down_next      = 1'b0;
            origin_seeded_next    = 1'b0;
            st_next.captured_code = CAP_NONE;
        end

        result.pressed = finger_down_next;
        result.cur_x   = finger_down_next ? st_next.last_x : '0;
        result.cur_y   = finger_down_next ? st_next.last_y : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finger_down_reg   <= 1'b0;
            origin_seeded_reg <= 1'b0;
            st_reg            <= '0;
        end else if (advance) begin
            finger_down_reg   <= finger_down_next;
            origin_seeded_reg <= origin_seeded_next;
            st_reg            <= st_next;
        end
    end

endmodule

FILE: rtl/touch_gesture_classifier_core.sv
// An accepted item goes first into the input register, then into the result register once
// that register is free or being drained.
// Throughput: one item per cycle while the result side keeps m_ready high.
// Reset (aresetn low, synchronous): both stages empty, touch state cleared to zero,
// enable = 1, tap_radius_sq = 900, swipe_min_travel = 40.
module touch_gesture_classifier_core
    import tgc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    // poll items in
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_data,
    // classified results out
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_data
);

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t result;
    logic      advance;

    // Move the held item into the result register when that slot is free or
    // being drained this cycle. The touch state updates in the same edge.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // Take a new item whenever the input register is empty or moving on, so a
    // result waiting downstream stalls the next poll only while an item is also held.
    assign s_ready = !in_valid_reg || advance;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration registers: writes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable           <= 1'b1;
            cfg_reg.tap_radius_sq    <= TAP_RADIUS_SQ_RST;
            cfg_reg.swipe_min_travel <= SWIPE_MIN_TRAVEL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENABLE:           cfg_reg.enable <= cfg_wdata[0];
                CFG_TAP_RADIUS_SQ:    cfg_reg.tap_radius_sq <= cfg_wdata[RADIUS_BITS-1:0];
                CFG_SWIPE_MIN_TRAVEL: cfg_reg.swipe_min_travel <= cfg_wdata[TRAVEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input stage: hold the poll until it advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Touch tracking and release classification on the held item.
    tgc_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result stage: load on advance, clear once taken with nothing behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule
